[design/ttcd_pkg.sv]
// Shared types and constants of the track table.
package ttcd_pkg;

  localparam int unsigned MaxTargetsDef = 8;

  typedef enum logic [1:0] {
    CMD_OBSERVE = 2'd0,
    CMD_EOF     = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_UPDATE  = 3'd0,
    KIND_ENTER   = 3'd1,
    KIND_DROPPED = 3'd2,
    KIND_EXIT    = 3'd3,
    KIND_NUMBER  = 3'd4,
    KIND_SUMMARY = 3'd5,
    KIND_CLEARED = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OBS,
    ST_MISS,
    ST_RANK,
    ST_SUM,
    ST_CLEAR
  } state_e;

  localparam logic [1:0] ZoneLeft   = 2'd0;
  localparam logic [1:0] ZoneCenter = 2'd1;
  localparam logic [1:0] ZoneRight  = 2'd2;

  localparam logic [7:0] RegConfirm = 8'd0;
  localparam logic [7:0] RegLost    = 8'd4;
  localparam logic [7:0] RegLeft    = 8'd8;
  localparam logic [7:0] RegRight   = 8'd12;

  // Command as queued between front and back.
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] id;
    logic [15:0] x;
    logic [1:0]  zone;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic        last;
    logic [31:0] primary_id;
    logic        primary_valid;
    logic [3:0]  active_count;
    logic [3:0]  rank;
    logic [1:0]  zone;
    logic [31:0] target_id;
    kind_e       kind;
  } res_t;

  // Signed compare-and-tie ordering: (x, id) strictly below (bx, bid).
  function automatic logic before_xy(logic signed [15:0] x, logic [31:0] id,
                                     logic signed [15:0] bx, logic [31:0] bid);
    before_xy = (x < bx) || ((x == bx) && (id < bid));
  endfunction

endpackage

[design/ttcd_front.sv]
// Front: accept commands, drop unused codes, classify the zone, queue the item.
module ttcd_front
  import ttcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [1:0]        s_cmd_i,
  input  logic [31:0]       s_id_i,
  input  logic [15:0]       s_x_i,
  input  logic signed [15:0] left_i,
  input  logic signed [15:0] right_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output cmd_t              q_data_o
);

  // Two-entry queue.
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       item;
  logic signed [15:0] xs;

  assign xs = $signed(s_x_i);
  always_comb begin
    item.cmd = cmd_e'(s_cmd_i);
    item.id  = s_id_i;
    item.x   = s_x_i;
    if (xs < left_i)       item.zone = ZoneLeft;
    else if (xs > right_i) item.zone = ZoneRight;
    else                   item.zone = ZoneCenter;
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign push      = s_valid_i && s_ready_o && (cmd_e'(s_cmd_i) != CMD_NONE);
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !s_ready_o) else $error("full queue accepts");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_o && !q_ready_i) |=> q_valid_o) else $error("queued item lost");

endmodule

[design/ttcd_back.sv]
// Back: table state, observation update and end-of-frame sequencer.
module ttcd_back
  import ttcd_pkg::*;
#(
  parameter int unsigned MaxTargets = MaxTargetsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  cmd_t              q_data_i,
  input  logic [15:0]       confirm_i,
  input  logic [15:0]       lost_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output res_t              m_data_o
);

  localparam int unsigned IW = (MaxTargets > 1) ? $clog2(MaxTargets) : 1;
  localparam int unsigned CW = $clog2(MaxTargets + 1);

  logic [MaxTargets-1:0] valid_q, seen_q, conf_q, ranked_q;
  logic [31:0] id_q   [MaxTargets];
  logic [15:0] x_q    [MaxTargets];
  logic [1:0]  zone_q [MaxTargets];
  logic [15:0] scnt_q [MaxTargets];
  logic [15:0] mcnt_q [MaxTargets];

  state_e state_q, state_d;
  cmd_t   cur_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] rank_q, act_q;
  logic   pv_q;
  logic [31:0] pid_q;
  logic [15:0] best_q;
  logic   out_v_q;
  res_t   out_q;
  res_t   res_d;
  logic   out_set;

  // Output register free or draining this cycle.
  logic   oslot;
  assign oslot = !out_v_q || m_ready_i;
  assign m_valid_o = out_v_q;
  assign m_data_o  = out_q;

  // Match and free slot search for observation.
  logic hit, fre;
  logic [IW-1:0] hit_i, fre_i;
  always_comb begin
    hit = 1'b0; fre = 1'b0; hit_i = '0; fre_i = '0;
    for (int i = MaxTargets - 1; i >= 0; i--) begin
      if (valid_q[i] && id_q[i] == cur_q.id) begin hit = 1'b1; hit_i = IW'(i); end
      if (!valid_q[i]) begin fre = 1'b1; fre_i = IW'(i); end
    end
  end

  // Minimum search over the active unranked entries.
  logic pick;
  logic [IW-1:0] pick_i;
  logic [MaxTargets-1:0] act;
  always_comb begin
    pick = 1'b0; pick_i = '0;
    act = valid_q & conf_q & seen_q;
    for (int i = 0; i < MaxTargets; i++) begin
      if (act[i] && !ranked_q[i] && (!pick ||
          before_xy($signed(x_q[i]), id_q[i], $signed(x_q[pick_i]), id_q[pick_i]))) begin
        pick = 1'b1; pick_i = IW'(i);
      end
    end
  end

  logic [15:0] sc_inc, mc_inc, ax;
  logic        last_idx, enter, better, drop_now;
  assign sc_inc = (scnt_q[hit_i] == 16'hFFFF) ? 16'hFFFF : scnt_q[hit_i] + 16'd1;
  assign mc_inc = (mcnt_q[idx_q] == 16'hFFFF) ? 16'hFFFF : mcnt_q[idx_q] + 16'd1;
  assign last_idx = (idx_q == IW'(MaxTargets - 1));
  assign ax = x_q[pick_i][15] ? (16'd0 - x_q[pick_i]) : x_q[pick_i];
  assign enter = hit && !conf_q[hit_i] && (sc_inc >= confirm_i);
  assign better = !pv_q || (ax < best_q) || ((ax == best_q) && (id_q[pick_i] < pid_q));
  assign drop_now = valid_q[idx_q] && !seen_q[idx_q] && (mc_inc >= lost_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (q_valid_i) begin
        case (q_data_i.cmd)
          CMD_OBSERVE: state_d = ST_OBS;
          CMD_EOF:     state_d = ST_MISS;
          CMD_CLEAR:   state_d = ST_CLEAR;
          default:     state_d = ST_IDLE;
        endcase
      end
      ST_OBS, ST_CLEAR, ST_SUM: if (oslot) state_d = ST_IDLE;
      ST_MISS: if (oslot && last_idx) state_d = ST_RANK;
      ST_RANK: if (oslot && !pick) state_d = ST_SUM;
      default: state_d = ST_IDLE;
    endcase
  end

  // Result to load and whether one is loaded this cycle.
  always_comb begin
    res_d = '0;
    out_set = 1'b0;
    case (state_q)
      ST_OBS: begin
        out_set = oslot;
        res_d.kind = (fre || hit) ? KIND_UPDATE : KIND_DROPPED;
        if (enter) res_d.kind = KIND_ENTER;
        res_d.target_id = cur_q.id;
        res_d.zone = cur_q.zone;
        res_d.last = 1'b1;
      end
      ST_MISS: begin
        out_set = oslot && drop_now && conf_q[idx_q];
        res_d.kind = KIND_EXIT;
        res_d.target_id = id_q[idx_q];
        res_d.zone = zone_q[idx_q];
      end
      ST_RANK: begin
        out_set = oslot && pick;
        res_d.kind = KIND_NUMBER;
        res_d.target_id = id_q[pick_i];
        res_d.zone = zone_q[pick_i];
        res_d.rank = 4'(rank_q + CW'(1));
      end
      ST_SUM: begin
        out_set = oslot;
        res_d.kind = KIND_SUMMARY;
        res_d.active_count = 4'(act_q);
        res_d.primary_valid = pv_q;
        res_d.primary_id = pv_q ? pid_q : 32'd0;
        res_d.last = 1'b1;
      end
      ST_CLEAR: begin
        out_set = oslot;
        res_d.kind = KIND_CLEARED;
        res_d.last = 1'b1;
      end
      default: ;
    endcase
  end

  assign q_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0; seen_q <= '0; conf_q <= '0; ranked_q <= '0;
      out_v_q <= 1'b0;
      idx_q <= '0; rank_q <= '0; act_q <= '0; pv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_set || (out_v_q && !m_ready_i);
      case (state_q)
        ST_IDLE: begin
          idx_q <= '0; rank_q <= '0; act_q <= '0; pv_q <= 1'b0; ranked_q <= '0;
        end
        ST_OBS: if (oslot) begin
          if (hit) begin
            seen_q[hit_i] <= 1'b1;
            if (enter) conf_q[hit_i] <= 1'b1;
          end else if (fre) begin
            valid_q[fre_i] <= 1'b1;
            seen_q[fre_i]  <= 1'b1;
            conf_q[fre_i]  <= 1'b0;
          end
        end
        ST_MISS: if (oslot) begin
          idx_q <= idx_q + IW'(1);
          if (drop_now) begin
            valid_q[idx_q] <= 1'b0;
            conf_q[idx_q]  <= 1'b0;
          end
        end
        ST_RANK: if (oslot && pick) begin
          ranked_q[pick_i] <= 1'b1;
          rank_q <= rank_q + CW'(1);
          act_q  <= act_q + CW'(1);
          if (better) pv_q <= 1'b1;
        end
        ST_SUM: if (oslot) begin
          seen_q <= '0;
        end
        ST_CLEAR: if (oslot) begin
          valid_q <= '0; seen_q <= '0; conf_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i) cur_q <= q_data_i;
    if (out_set) out_q <= res_d;
    case (state_q)
      ST_OBS: if (oslot) begin
        if (hit) begin
          scnt_q[hit_i] <= sc_inc;
          mcnt_q[hit_i] <= '0;
          x_q[hit_i]    <= cur_q.x;
          zone_q[hit_i] <= cur_q.zone;
        end else if (fre) begin
          id_q[fre_i]   <= cur_q.id;
          x_q[fre_i]    <= cur_q.x;
          zone_q[fre_i] <= cur_q.zone;
          scnt_q[fre_i] <= 16'd1;
          mcnt_q[fre_i] <= '0;
        end
      end
      ST_MISS: if (oslot && valid_q[idx_q] && !seen_q[idx_q]) begin
        mcnt_q[idx_q] <= mc_inc;
      end
      ST_RANK: if (oslot && pick && better) begin
        best_q <= ax;
        pid_q  <= id_q[pick_i];
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (conf_q & ~valid_q) == '0) else $error("confirmed slot not valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q & ~valid_q) == '0) else $error("seen slot not valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && !m_ready_i) |=> $stable(m_data_o)) else $error("result changed");

endmodule

[design/track_table_confirm_drop.sv]
// Top level of the track confirmation and deletion table.
//  channel  dir  handshake        payload
//  s_axis   in   tvalid/tready    tdata cmd, body_id, pelvis_x
//  m_axis   out  tvalid/tready    tdata kind..primary_id, tlast last
//  apb      in   psel/penable     four 16-bit registers
// Observation: the sequencer takes the item from the queue, then executes it and loads the
// result register; a clear passes through the same take and execute steps. End of frame:
// take, a miss pass over every slot (MaxTargets), a rank pass that numbers each active
// entry until none is left, then the summary. Reset clears all valid, seen and confirmed
// bits at once. A stalled result output holds the sequencer; the front queue holds two.
module track_table_confirm_drop
  import ttcd_pkg::*;
#(
  parameter int unsigned MaxTargets = MaxTargetsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [55:0]  s_axis_tdata_i, // cmd[1:0], body_id[33:2], pelvis_x[49:34]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // kind[2:0], target_id[34:3], zone[36:35], rank[40:37], active_count[44:41],
  // primary_valid[45], primary_id[77:46]
  output logic [79:0]  m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0] confirm_q, lost_q, left_q, right_q;
  logic        q_valid, q_ready;
  cmd_t        q_data;
  res_t        res;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_q <= 16'd30;
      lost_q    <= 16'd30;
      left_q    <= 16'hFE0C;
      right_q   <= 16'd500;
    end else if (psel && penable && pwrite) begin
      case ({4'd0, paddr})
        RegConfirm: confirm_q <= pwdata[15:0];
        RegLost:    lost_q    <= pwdata[15:0];
        RegLeft:    left_q    <= pwdata[15:0];
        RegRight:   right_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case ({4'd0, paddr})
      RegConfirm: prdata = {16'd0, confirm_q};
      RegLost:    prdata = {16'd0, lost_q};
      RegLeft:    prdata = {{16{left_q[15]}}, left_q};
      RegRight:   prdata = {{16{right_q[15]}}, right_q};
      default:    prdata = '0;
    endcase
  end

  ttcd_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid_i), .s_ready_o(s_axis_tready_o),
    .s_cmd_i(s_axis_tdata_i[1:0]), .s_id_i(s_axis_tdata_i[33:2]),
    .s_x_i(s_axis_tdata_i[49:34]),
    .left_i($signed(left_q)), .right_i($signed(right_q)),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  ttcd_back #(.MaxTargets(MaxTargets)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .confirm_i(confirm_q), .lost_i(lost_q),
    .m_valid_o(m_axis_tvalid_o), .m_ready_i(m_axis_tready_i), .m_data_o(res)
  );

  assign m_axis_tdata_o = {2'b00, res.primary_id, res.primary_valid, res.active_count,
                           res.rank, res.zone, res.target_id, res.kind};
  assign m_axis_tlast_o = res.last;

endmodule
